// ===== rtl/core/mix_minus_audio_mixer_macros.svh =====
// Assertion macros for the mix-minus mixer checker.
// No dependencies; take in with a plain include.
`ifndef MIX_MINUS_AUDIO_MIXER_MACROS_SVH
`define MIX_MINUS_AUDIO_MIXER_MACROS_SVH

// Concurrent assertion, switched off while reset is held.
`define MMX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also runs through reset.
`define MMX_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mmx_pkg.sv =====
// Types and constants for the mix-minus audio mixer.
// No dependencies.
package mmx_pkg;

    localparam int NSRC      = 4;   // sources carried on the input word
    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int VAD_W     = 8;
    localparam int PROD_W    = 33;  // s16 x u16
    localparam int ACC_W     = 35;  // four products
    localparam int SCALED_W  = 51;  // acc x 16-bit attenuation
    localparam int OUT_SHIFT = 27;  // Q4.12 gain plus 15-bit attenuation
    localparam int ONE_SHIFT = 15;  // attenuation of exactly 1.0

    localparam logic signed [15:0] ATTEN_MULTI = 16'sd29491;  // ~0.9 in Q0.15
    localparam logic [10:0]        RECIP3      = 11'd683;     // 2048/3, rounded up

    // config register indexes
    localparam logic [2:0] REG_GAIN0  = 3'd0;
    localparam logic [2:0] REG_GAIN1  = 3'd1;
    localparam logic [2:0] REG_GAIN2  = 3'd2;
    localparam logic [2:0] REG_GAIN3  = 3'd3;
    localparam logic [2:0] REG_INCL   = 3'd4;
    localparam logic [2:0] REG_VADEN  = 3'd5;
    localparam logic [2:0] REG_OUTEN  = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [GAIN_W-1:0]          t_gain;
    typedef logic [VAD_W-1:0]           t_vad;

    // one channel handed from the sequencer to the datapath
    typedef struct packed {
        logic                 vld;
        logic [1:0]           ch;
        logic                 last;
        logic [NSRC-1:0]      mix;
        logic [NSRC-1:0][7:0] vad;
    } t_issue;

    // one finished result word
    typedef struct packed {
        logic        vld;
        logic [1:0]  ch;
        logic        last;
        t_sample     sample;
        t_vad        vad;
    } t_result;

endpackage

// ===== rtl/core/mmx_mix_pipe.sv =====
// Three-stage mix datapath plus output register for the mix-minus mixer.
// Depends on mmx_pkg.
module mmx_mix_pipe import mmx_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_issue               i_issue,
    input  t_sample [NSRC-1:0]   i_sample,
    input  t_gain   [NSRC-1:0]   i_gain,
    input  logic                 i_ready,
    output logic                 o_adv,
    output t_result              o_result
);

    // stage 1: masked products, count, vad sum
    logic                          r1_v;
    logic [1:0]                    r1_ch;
    logic                          r1_last;
    logic signed [PROD_W-1:0]      r1_prod [NSRC];
    logic [2:0]                    r1_cnt;
    logic [9:0]                    r1_vsum;
    // stage 2: accumulated sum, vad average
    logic                          r2_v;
    logic [1:0]                    r2_ch;
    logic                          r2_last;
    logic signed [ACC_W-1:0]       r2_acc;
    logic                          r2_multi;
    t_vad                          r2_vad;
    // stage 3: attenuated sum
    logic                          r3_v;
    logic [1:0]                    r3_ch;
    logic                          r3_last;
    logic signed [SCALED_W-1:0]    r3_res;
    t_vad                          r3_vad;
    // output word
    logic                          r_out_v;
    logic [1:0]                    r_out_ch;
    logic                          r_out_last;
    t_sample                       r_out_sample;
    t_vad                          r_out_vad;

    logic signed [PROD_W-1:0]      n_prod [NSRC];
    logic [2:0]                    n_cnt;
    logic [9:0]                    n_vsum;
    logic signed [ACC_W-1:0]       n_acc;
    t_vad                          n_vad;
    logic [20:0]                   vdiv3;
    logic signed [SCALED_W-1:0]    n_res;
    logic signed [SCALED_W-1:0]    res_adj;
    logic signed [23:0]            quot;
    t_sample                       n_sample;

    assign o_adv    = !r_out_v || i_ready;
    assign o_result = '{vld: r_out_v, ch: r_out_ch, last: r_out_last,
                        sample: r_out_sample, vad: r_out_vad};

    always_comb begin
        n_cnt  = '0;
        n_vsum = '0;
        for (int s = 0; s < NSRC; s++) begin
            n_prod[s] = i_issue.mix[s] ?
                        PROD_W'($signed(i_sample[s])) * PROD_W'($signed({1'b0, i_gain[s]}))
                        : '0;
            n_cnt     = n_cnt + 3'(i_issue.mix[s]);
            n_vsum    = n_vsum + 10'(i_issue.vad[s]);
        end
    end

    always_comb begin
        n_acc = '0;
        for (int s = 0; s < NSRC; s++) begin
            n_acc = n_acc + ACC_W'(r1_prod[s]);
        end
        vdiv3 = 21'(r1_vsum) * 21'(RECIP3);
        case (r1_cnt)
            3'd1:    n_vad = r1_vsum[7:0];
            3'd2:    n_vad = r1_vsum[8:1];
            3'd3:    n_vad = vdiv3[18:11];
            3'd4:    n_vad = r1_vsum[9:2];
            default: n_vad = '0;
        endcase
    end

    assign n_res = r2_multi ? SCALED_W'(r2_acc) * SCALED_W'(ATTEN_MULTI)
                            : SCALED_W'(r2_acc) <<< ONE_SHIFT;

    // divide by 2^27 truncating toward zero, then saturate
    always_comb begin
        res_adj = r3_res + (r3_res[SCALED_W-1] ? SCALED_W'((64'd1 << OUT_SHIFT) - 64'd1)
                                               : SCALED_W'(0));
        quot    = 24'(res_adj >>> OUT_SHIFT);
        if (quot > 24'sd32767) begin
            n_sample = 16'sh7fff;
        end else if (quot < -24'sd32768) begin
            n_sample = 16'sh8000;
        end else begin
            n_sample = quot[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (o_adv) begin
            r1_v    <= i_issue.vld;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_out_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r1_ch      <= i_issue.ch;
            r1_last    <= i_issue.last;
            r1_prod    <= n_prod;
            r1_cnt     <= n_cnt;
            r1_vsum    <= n_vsum;
            r2_ch      <= r1_ch;
            r2_last    <= r1_last;
            r2_acc     <= n_acc;
            r2_multi   <= r1_cnt > 3'd1;
            r2_vad     <= n_vad;
            r3_ch      <= r2_ch;
            r3_last    <= r2_last;
            r3_res     <= n_res;
            r3_vad     <= r2_vad;
            r_out_ch     <= r3_ch;
            r_out_last   <= r3_last;
            r_out_sample <= n_sample;
            r_out_vad    <= r3_vad;
        end
    end

endmodule

// ===== rtl/core/mix_minus_audio_mixer.sv =====
// Mix-minus conference mixer: one word in, one result per enabled channel out.
// Each result passes the held input word, the pipe's stage registers and its output.
// Throughput: one result per cycle while the output is not stalled, set by the
//   channel sequencer feeding the single mix pipeline one channel at a time.
// Reset (sync, active low) empties the pipeline and sets gains to 1.0,
//   include-self and vad-enable to 0 and all outputs enabled.
module mix_minus_audio_mixer import mmx_pkg::*; #(
    parameter int NUM_SOURCES = 4   // 2..8; above 4 acts as 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input words
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // [15:0] sample_src0, [31:16] sample_src1, [47:32] sample_src2,
    // [63:48] sample_src3, [71:64] vad_src0, [79:72] vad_src1,
    // [87:80] vad_src2, [95:88] vad_src3, [99:96] active_mask, [103:100] zero
    input  logic [103:0]  i_s_axis_tdata,
    // result words
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // [15:0] mixed_sample, [23:16] mixed_vad
    output logic [23:0]   o_m_axis_tdata,
    // [1:0] out_channel
    output logic [1:0]    o_m_axis_tuser,
    output logic          o_m_axis_tlast,  // last_of_item
    // config writes
    input  logic          i_cfg_wen,
    input  logic [2:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata
);

    // Only the first min(NUM_SOURCES, 4) sources and channels take part.
    localparam int         USED      = (NUM_SOURCES > NSRC) ? NSRC : NUM_SOURCES;
    localparam logic [3:0] USED_MASK = 4'((1 << USED) - 1);

    // config
    t_gain [NSRC-1:0]  r_gain;
    logic  [3:0]       r_incl;
    logic  [3:0]       r_vad_en;
    logic  [3:0]       r_out_en;

    // held input word and channels still to issue
    logic                   r_item_v;
    logic [3:0]             r_pend;
    t_sample [NSRC-1:0]     r_sample;
    logic [NSRC-1:0][7:0]   r_vad;
    logic [3:0]             r_active;

    logic        adv;
    logic        in_acc;
    logic [3:0]  n_pend;
    logic [1:0]  sel_ch;
    logic [3:0]  sel_hot;
    logic [3:0]  rest;
    logic        sel_last;
    t_issue      issue;
    t_result     result;
    t_vad        eff_vad;

    // ---------------------------------------------------------------
    // Config registers. Index 7 matches nothing and is dropped.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= {NSRC{GAIN_UNITY}};
            r_incl   <= '0;
            r_vad_en <= '0;
            r_out_en <= 4'hf;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                REG_GAIN0: r_gain[0] <= i_cfg_wdata;
                REG_GAIN1: r_gain[1] <= i_cfg_wdata;
                REG_GAIN2: r_gain[2] <= i_cfg_wdata;
                REG_GAIN3: r_gain[3] <= i_cfg_wdata;
                REG_INCL:  r_incl    <= i_cfg_wdata[3:0];
                REG_VADEN: r_vad_en  <= i_cfg_wdata[3:0];
                REG_OUTEN: r_out_en  <= i_cfg_wdata[3:0];
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Channel sequencer: lowest pending channel goes out each time the
    // pipeline advances. The next word is taken in the same cycle the
    // last channel of the current one is issued.
    // ---------------------------------------------------------------
    always_comb begin
        sel_ch  = '0;
        sel_hot = '0;
        for (int c = NSRC - 1; c >= 0; c--) begin
            if (r_pend[c]) begin
                sel_ch  = 2'(c);
                sel_hot = 4'(1 << c);
            end
        end
        rest     = r_pend & ~sel_hot;
        sel_last = (rest == '0);
    end

    assign o_s_axis_tready = !r_item_v || (adv && sel_last);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign n_pend          = r_out_en & USED_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_v <= 1'b0;
            r_pend   <= '0;
        end else if (in_acc) begin
            // a word with no enabled channel is taken and gives nothing
            r_item_v <= |n_pend;
            r_pend   <= n_pend;
        end else if (r_item_v && adv) begin
            r_pend <= rest;
            if (sel_last) begin
                r_item_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int s = 0; s < NSRC; s++) begin
                r_sample[s] <= i_s_axis_tdata[16*s +: 16];
                r_vad[s]    <= i_s_axis_tdata[64 + 8*s +: 8];
            end
            r_active <= i_s_axis_tdata[99:96];
        end
    end

    // Source selection for the issued channel. A source mixes when it is
    // active, in use, not the channel's own (unless include-self), and its
    // effective vad is nonzero; vad counts as 1 when its enable is off.
    always_comb begin
        issue.vld  = r_item_v;
        issue.ch   = sel_ch;
        issue.last = sel_last;
        for (int s = 0; s < NSRC; s++) begin
            eff_vad = r_vad_en[s] ? r_vad[s] : 8'd1;
            issue.mix[s] = r_active[s] && USED_MASK[s] && (eff_vad != '0) &&
                           ((2'(s) != sel_ch) || r_incl[sel_ch]);
            issue.vad[s] = issue.mix[s] ? eff_vad : '0;
        end
    end

    mmx_mix_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_sample (r_sample),
        .i_gain   (r_gain),
        .i_ready  (i_m_axis_tready),
        .o_adv    (adv),
        .o_result (result)
    );

    assign o_m_axis_tvalid = result.vld;
    assign o_m_axis_tdata  = {result.vad, result.sample};
    assign o_m_axis_tuser  = result.ch;
    assign o_m_axis_tlast  = result.last;

endmodule

// ===== rtl/core/mmx_checker.sv =====
// Port-level checks for the mix-minus mixer, bound to its top level.
// Depends on mix_minus_audio_mixer_macros.svh.
`include "mix_minus_audio_mixer_macros.svh"

module mmx_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [23:0]  o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser,
    input logic         o_m_axis_tlast
);

    logic        r_mid;      // inside a word's run of results
    logic [1:0]  r_prev_ch;
    logic        out_acc;

    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_prev_ch <= '0;
        end else if (out_acc) begin
            r_mid     <= !o_m_axis_tlast;
            r_prev_ch <= o_m_axis_tuser;
        end
    end

    // a stalled result word holds
    `MMX_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast)), "result word changed while stalled")

    // channels of one word come out in rising order
    `MMX_ASSERT(a_ch_order, i_clk, i_rst_n, (out_acc && r_mid) |-> (o_m_axis_tuser > r_prev_ch), "channel order broken within a word")

    // reset empties the pipe and opens the input
    `MMX_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready), "not empty after reset")

endmodule

bind mix_minus_audio_mixer mmx_checker u_mmx_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== tb/mix_minus_audio_mixer_tb.sv =====
// Self-checking testbench for the mix-minus conference mixer.
// Needs mmx_pkg and mix_minus_audio_mixer; predicts each channel's mix per input word
// and checks every result word in order under random idling and a long output stall.
module mix_minus_audio_mixer_tb import mmx_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Register index past the end of the map: the block must ignore writes to it.
    localparam logic [2:0] REG_SPARE   = 3'd7;
    localparam longint     ATTEN_UNITY = longint'(1) << ONE_SHIFT;
    localparam int         SETTLE_CYC  = 16;   // margin for the pipeline to run dry
    localparam int         HOLD_CYC    = 300;  // long output stall
    localparam int         CHUNKS      = 10;
    localparam int         CHUNK_WORDS = 41;

    // Input word layout, first field in the lowest bits (packed struct runs MSB first).
    typedef struct packed {
        logic [3:0]                pad;
        logic [NSRC-1:0]           active;
        logic [NSRC-1:0][VAD_W-1:0]    vad;
        logic [NSRC-1:0][SAMPLE_W-1:0] smp;
    } mix_word_t;

    typedef struct packed {
        logic [1:0] ch;
        t_sample    smp;
        t_vad       vad;
        logic       last;
    } mix_result_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_axis_tvalid = 1'b0;
    logic          o_s_axis_tready;
    logic [103:0]  i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 1'b0;
    logic [23:0]   o_m_axis_tdata;
    logic [1:0]    o_m_axis_tuser;
    logic          o_m_axis_tlast;
    logic          i_cfg_wen = 1'b0;
    logic [2:0]    i_cfg_addr = '0;
    logic [15:0]   i_cfg_wdata = '0;

    mix_minus_audio_mixer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // Words waiting for the driver, and the results the mixer owes us, oldest first.
    mix_word_t   word_queue[$];
    mix_result_t mix_expected[$];

    // Shadow copy of the mixer's registers, kept in step with every write.
    t_gain       gain_sh[NSRC];
    logic [3:0]  incl_sh;
    logic [3:0]  vaden_sh;
    logic [3:0]  outen_sh;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          fails = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: the slowest legal run is far shorter than this.
    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Mix predictor: works out every channel's result for one word
    // ------------------------------------------------------------------
    function automatic void predict_mix(input mix_word_t w);
        longint      acc;
        longint      res;
        int unsigned n_mix;
        int unsigned vad_sum;
        int unsigned v;
        mix_result_t r;
        bit          any;
        any = 1'b0;
        for (int ch = 0; ch < NSRC; ch++) begin
            if (!outen_sh[ch]) continue;
            acc = 0;
            n_mix = 0;
            vad_sum = 0;
            for (int s = 0; s < NSRC; s++) begin
                // a source counts only when active, not the channel's own
                // (unless include-self), and voice-active
                if (!w.active[s])
                    v = 0;
                else if (s == ch && !incl_sh[ch])
                    v = 0;
                else if (vaden_sh[s])
                    v = w.vad[s];
                else
                    v = 1;
                if (v != 0) begin
                    acc += longint'($signed(w.smp[s])) * longint'(gain_sh[s]);
                    n_mix++;
                    vad_sum += v;
                end
            end
            // 0.9 only when two or more sources were summed; divide truncates toward zero
            res = acc * ((n_mix > 1) ? longint'(ATTEN_MULTI) : ATTEN_UNITY);
            res = res / (longint'(1) << OUT_SHIFT);
            if (res > 32767)
                res = 32767;
            else if (res < -32768)
                res = -32768;
            r.ch   = ch[1:0];
            r.smp  = res[15:0];
            r.vad  = (n_mix != 0) ? t_vad'(vad_sum / n_mix) : '0;
            r.last = 1'b0;
            mix_expected.push_back(r);
            any = 1'b1;
        end
        // flag the final result of the word
        if (any) begin
            r = mix_expected.pop_back();
            r.last = 1'b1;
            mix_expected.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: presents queued words, idles at random between them
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            // the word on the bus at this edge is taken: predict its results now
            if (i_s_axis_tvalid && o_s_axis_tready)
                predict_mix(i_s_axis_tdata);
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (word_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    i_s_axis_tdata  <= word_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            // sender keeps offering while we refuse: pipeline fills, input stalls
            hold_left       <= HOLD_CYC;
            hold_done       <= 1'b1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        mix_result_t got;
        mix_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.ch   = o_m_axis_tuser;
            got.smp  = o_m_axis_tdata[15:0];
            got.vad  = o_m_axis_tdata[23:16];
            got.last = o_m_axis_tlast;
            if (mix_expected.size() == 0) begin
                $error("unexpected result word: ch %0d sample %0d vad %0d last %0b",
                       got.ch, got.smp, got.vad, got.last);
                fails++;
            end else begin
                want = mix_expected.pop_front();
                if (got.ch !== want.ch) begin
                    $error("out_channel: expected %0d, got %0d", want.ch, got.ch);
                    fails++;
                end
                if (got.smp !== want.smp) begin
                    $error("mixed_sample: expected %0d, got %0d", want.smp, got.smp);
                    fails++;
                end
                if (got.vad !== want.vad) begin
                    $error("mixed_vad: expected %0d, got %0d", want.vad, got.vad);
                    fails++;
                end
                if (got.last !== want.last) begin
                    $error("last_of_item: expected %0b, got %0b", want.last, got.last);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // samples packed {s3,s2,s1,s0}, vads {v3,v2,v1,v0}
    function automatic void queue_word(input logic [3:0] act, input logic [63:0] smps,
                                       input logic [31:0] vads);
        mix_word_t w;
        w.pad    = '0;
        w.active = act;
        w.vad    = vads;
        w.smp    = smps;
        word_queue.push_back(w);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_vad();
        case ($urandom_range(0, 5))
            0, 1:    return 8'd0;
            2:       return 8'hFF;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic t_gain pick_gain();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return GAIN_UNITY + 16'($urandom_range(0, 1024)) - 16'd512;
            default: return t_gain'($urandom);
        endcase
    endfunction

    // One register write, clocked at the rising edge; the shadow follows.
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_GAIN0: gain_sh[0] = data;
            REG_GAIN1: gain_sh[1] = data;
            REG_GAIN2: gain_sh[2] = data;
            REG_GAIN3: gain_sh[3] = data;
            REG_INCL:  incl_sh    = data[3:0];
            REG_VADEN: vaden_sh   = data[3:0];
            REG_OUTEN: outen_sh   = data[3:0];
            default:   ;
        endcase
    endtask

    // Rewrites the whole map; mask writes carry junk above bit 3, and the spare
    // index gets a junk write that must change nothing.
    task automatic apply_settings(input t_gain g0, input t_gain g1, input t_gain g2,
                                  input t_gain g3, input logic [3:0] incl,
                                  input logic [3:0] vaden, input logic [3:0] outen);
        logic [15:0] d;
        cfg_write(REG_GAIN0, g0);
        cfg_write(REG_GAIN1, g1);
        cfg_write(REG_GAIN2, g2);
        cfg_write(REG_GAIN3, g3);
        d = 16'($urandom);
        d[3:0] = incl;
        cfg_write(REG_INCL, d);
        d = 16'($urandom);
        d[3:0] = vaden;
        cfg_write(REG_VADEN, d);
        d = 16'($urandom);
        d[3:0] = outen;
        cfg_write(REG_OUTEN, d);
        cfg_write(REG_SPARE, 16'($urandom));
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    // Waits for every word to go in and every result to come out, then lets
    // the pipeline run dry (words with no enabled channel leave no trace).
    task automatic drain_and_settle();
        do @(negedge i_clk);
        while (word_queue.size() != 0 || i_s_axis_tvalid || mix_expected.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        logic [63:0] smps;
        logic [31:0] vads;

        // reset values of the register map
        for (int s = 0; s < NSRC; s++) gain_sh[s] = GAIN_UNITY;
        incl_sh  = 4'h0;
        vaden_sh = 4'h0;
        outen_sh = 4'hF;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 24;
        rx_idle_pct = 83;

        // --- directed, reset settings: unity gains, vad ignored, no self ---
        queue_word(4'h0, 64'h0, 32'h0);                           // nothing mixed
        queue_word(4'hF, {4{16'h7FFF}}, {4{8'hFF}});              // clip high
        queue_word(4'hF, {4{16'h8000}}, {4{8'hFF}});              // clip low
        queue_word(4'h1, {48'h0, 16'h7FFF}, 32'h0);               // one source, no 0.9
        queue_word(4'h3, {32'h0, 16'd1000, 16'd1000}, 32'h0);     // two sources, 0.9
        queue_word(4'h6, {16'h0, 16'h0, 16'hFFFD, 16'h0}, 32'h0); // negative truncation
        queue_word(4'hF, {16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0}, 32'h01020304);
        drain_and_settle();

        // --- directed: exact full scale, include-self, vad in use ---
        apply_settings(16'd8192, 16'hFFFF, 16'h0000, GAIN_UNITY, 4'hF, 4'hF, 4'hF);
        queue_word(4'h1, {48'h0, 16'd16384}, {24'h0, 8'hFF});     // exactly +1.0
        queue_word(4'hF, {4{16'h7FFF}}, {8'd128, 8'd1, 8'd0, 8'd255});
        queue_word(4'hF, {4{16'h8000}}, {4{8'hFF}});
        queue_word(4'hF, {4{16'h7FFF}}, 32'h0);                   // all silent
        queue_word(4'hF, {4{16'hFFFF}}, {8'd2, 8'd2, 8'd3, 8'd3});  // vad average rounds down
        drain_and_settle();

        // --- directed: no channel enabled, so no results at all ---
        apply_settings(16'd8192, 16'hFFFF, 16'h0000, GAIN_UNITY, 4'hF, 4'hF, 4'h0);
        queue_word(4'hF, {4{16'h7FFF}}, {4{8'hFF}});
        queue_word(4'hA, {4{16'h5555}}, {4{8'hAA}});
        drain_and_settle();

        // --- directed: sparse outputs, mixed self and vad masks ---
        apply_settings(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, 16'hFFFF, 4'hA, 4'h3, 4'h5);
        queue_word(4'hF, {16'h0100, 16'h0200, 16'h0300, 16'h0400}, {8'd0, 8'd0, 8'd0, 8'd9});
        queue_word(4'hF, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, {8'd0, 8'd7, 8'd0, 8'd0});
        queue_word(4'h8, {16'h0001, 48'h0}, 32'h0);
        queue_word(4'h5, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, {8'h55, 8'hAA, 8'h55, 8'hAA});
        drain_and_settle();

        // --- random words in chunks, new settings for each chunk ---
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk)
                0: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 4'hF);
                1: apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'h0, 4'h0, 4'hF);
                default:
                    apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                   4'($urandom_range(1, 15)));
            endcase
            // idling: sender eager/receiver busy, then swapped, then flat out
            if (chunk < 4) begin
                tx_idle_pct = 24;
                rx_idle_pct = 83;
            end else if (chunk < 7) begin
                tx_idle_pct = 83;
                rx_idle_pct = 24;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (chunk == 8) hold_go = 1'b1;
            for (int k = 0; k < CHUNK_WORDS; k++) begin
                for (int s = 0; s < NSRC; s++) begin
                    smps[s*16 +: 16] = pick_sample();
                    vads[s*8 +: 8]   = pick_vad();
                end
                queue_word(4'($urandom_range(0, 15)), smps, vads);
            end
            drain_and_settle();
        end

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== mix_minus_audio_mixer.f =====
+incdir+rtl/core
rtl/core/mmx_pkg.sv
rtl/core/mmx_mix_pipe.sv
rtl/core/mix_minus_audio_mixer.sv
rtl/core/mmx_checker.sv
tb/mix_minus_audio_mixer_tb.sv
